// File: hdl/pfc_pkg.sv
// pfc_pkg: shared types and constants for the pixel format converter
// no dependencies; imported by every module of the block except pfc_ram

package pfc_pkg;

   // request kinds
   localparam logic REQ_CONVERT       = 1'b0;
   localparam logic REQ_PALETTE_WRITE = 1'b1;

   // configuration register indexes
   localparam logic CSR_SOURCE_LAYOUT = 1'b0;
   localparam logic CSR_DEST_LAYOUT   = 1'b1;

   // fixed field widths
   localparam int LAYOUT_W = 3;
   localparam int CSR_IDX_W = 1;

   // colour constants
   localparam logic [7:0] FULL_ALPHA = 8'hff;
   localparam logic [7:0] NO_COLOUR  = 8'h00;

   // valid byte counts of a result
   localparam logic [2:0] BYTES_ONE   = 3'd1;
   localparam logic [2:0] BYTES_THREE = 3'd3;
   localparam logic [2:0] BYTES_FOUR  = 3'd4;

   // front-to-back queue, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [LAYOUT_W-1:0] {
      SRC_INDEX8 = 3'd0,
      SRC_RGB    = 3'd1,
      SRC_RGBA   = 3'd2,
      SRC_ARGB   = 3'd3,
      SRC_BGR    = 3'd4,
      SRC_BGRA   = 3'd5,
      SRC_ABGR   = 3'd6,
      SRC_ALPHA  = 3'd7
   } src_layout_type;

   typedef enum logic [LAYOUT_W-1:0] {
      DST_RGB   = 3'd0,
      DST_RGBA  = 3'd1,
      DST_ARGB  = 3'd2,
      DST_BGR   = 3'd3,
      DST_BGRA  = 3'd4,
      DST_ABGR  = 3'd5,
      DST_ALPHA = 3'd6
   } dst_layout_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] pixel_bytes;
      logic [7:0]  entry_index;
      logic [31:0] entry_color;
      logic        row_end_in;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_pixel;
      logic [2:0]  out_bytes;
      logic        row_end_out;
   } rsp_payload_type;

   // decoded pixel handed from front to back
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       row_end;
   } pixel_type;

   // handshake between two internal stages
   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

endpackage

// File: hdl/pixel_format_converter_unit.sv
// pixel_format_converter_unit: throughput one request per cycle while rsp_ready
// does not hold the output register; palette writes give no response.
// The palette memory read is issued as a convert request is taken, decode
// follows on the registered read data, a 2-entry queue feeds the packer.
// Synchronous active-high reset clears control state and sets the layouts
// to rgba source and rgba destination; palette contents are undefined.

module pixel_format_converter_unit
   import pfc_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LAYOUT_W-1:0]  csr_wdata
);

   logic [LAYOUT_W-1:0] src_layout_ff;
   logic [LAYOUT_W-1:0] dst_layout_ff;
   link_type            push;
   logic                push_ready;
   pixel_type           push_data;
   logic                pop_valid;
   logic                pop_ready;
   pixel_type           pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_layout_ff <= SRC_RGBA;
         dst_layout_ff <= DST_RGBA;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_LAYOUT: src_layout_ff <= csr_wdata;
            CSR_DEST_LAYOUT:   dst_layout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // front: request intake, palette and source decode
   pfc_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .src_layout  (src_layout_type'(src_layout_ff)),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // decoupling queue
   pfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: destination pack and output register
   pfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .dst_layout  (dst_layout_type'(dst_layout_ff)),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/pfc_ram.sv
// pfc_ram: generic single-write, single-read memory with registered read data
// no dependencies

module pfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pfc_front.sv
// pfc_front: accepts requests, writes the palette, decodes source pixels
// depends on pfc_pkg and pfc_ram

module pfc_front
   import pfc_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  src_layout_type  src_layout,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output link_type        push,
   input  logic            push_ready,
   output pixel_type       push_data
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic        accept;
   logic        acc_convert;
   logic        acc_write;
   logic        wr_in_range;
   logic        rd_in_range;
   logic [31:0] entry;
   logic [31:0] px;

   logic        fv_ff, fv_in;
   logic [31:0] pixel_ff;
   logic        row_end_ff;
   logic        oob_ff;

   // request classification
   assign req_ready   = !fv_ff || push_ready;
   assign accept      = req_valid && req_ready;
   assign acc_convert = accept && (req_payload.req_type == REQ_CONVERT);
   assign acc_write   = accept && (req_payload.req_type == REQ_PALETTE_WRITE);
   assign wr_in_range = 32'(req_payload.entry_index) < PALETTE_DEPTH;
   assign rd_in_range = 32'(req_payload.pixel_bytes[7:0]) < PALETTE_DEPTH;

   // palette store, read issued as the convert request is taken
   pfc_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (acc_write && wr_in_range),
      .wr_addr (req_payload.entry_index[AW-1:0]),
      .wr_data (req_payload.entry_color),
      .rd_en   (acc_convert),
      .rd_addr (req_payload.pixel_bytes[AW-1:0]),
      .rd_data (entry)
   );

   // front stage occupancy
   always_comb begin
      if (acc_convert) begin
         fv_in = 1'b1;
      end else if (push_ready) begin
         fv_in = 1'b0;
      end else begin
         fv_in = fv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
   end

   // front stage payload
   always_ff @(posedge clock) begin
      if (acc_convert) begin
         pixel_ff   <= req_payload.pixel_bytes;
         row_end_ff <= req_payload.row_end_in;
         oob_ff     <= !rd_in_range;
      end
   end

   // source layout decode
   always_comb begin
      px = pixel_ff;
      push_data.red     = NO_COLOUR;
      push_data.green   = NO_COLOUR;
      push_data.blue    = NO_COLOUR;
      push_data.alpha   = FULL_ALPHA;
      push_data.row_end = row_end_ff;
      unique case (src_layout)
         SRC_INDEX8: begin
            px = oob_ff ? 32'd0 : entry;
            push_data.red   = px[7:0];
            push_data.green = px[15:8];
            push_data.blue  = px[23:16];
            push_data.alpha = px[31:24];
         end
         SRC_RGB: begin
            push_data.red   = px[7:0];
            push_data.green = px[15:8];
            push_data.blue  = px[23:16];
         end
         SRC_RGBA: begin
            push_data.red   = px[7:0];
            push_data.green = px[15:8];
            push_data.blue  = px[23:16];
            push_data.alpha = px[31:24];
         end
         SRC_ARGB: begin
            push_data.alpha = px[7:0];
            push_data.red   = px[15:8];
            push_data.green = px[23:16];
            push_data.blue  = px[31:24];
         end
         SRC_BGR: begin
            push_data.blue  = px[7:0];
            push_data.green = px[15:8];
            push_data.red   = px[23:16];
         end
         SRC_BGRA: begin
            push_data.blue  = px[7:0];
            push_data.green = px[15:8];
            push_data.red   = px[23:16];
            push_data.alpha = px[31:24];
         end
         SRC_ABGR: begin
            push_data.alpha = px[7:0];
            push_data.blue  = px[15:8];
            push_data.green = px[23:16];
            push_data.red   = px[31:24];
         end
         SRC_ALPHA: begin
            push_data.alpha = px[7:0];
         end
         default: begin
            push_data.alpha = px[7:0];
         end
      endcase
   end

   assign push.valid = fv_ff;
   assign push.ready = push_ready;

endmodule

// File: hdl/pfc_queue.sv
// pfc_queue: short queue of decoded pixels between front and back
// depends on pfc_pkg

module pfc_queue
   import pfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  link_type  push,
   output logic      push_ready,
   input  pixel_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output pixel_type pop_data
);

   pixel_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/pfc_back.sv
// pfc_back: packs decoded pixels into the destination layout, output register
// depends on pfc_pkg

module pfc_back
   import pfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dst_layout_type  dst_layout,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  pixel_type       pop_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type packed_px;
   logic            load;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   // destination layout pack, unknown codes give alpha only
   always_comb begin
      packed_px.row_end_out = pop_data.row_end;
      packed_px.out_bytes   = BYTES_FOUR;
      unique case (dst_layout)
         DST_RGB: begin
            packed_px.out_pixel = {NO_COLOUR, pop_data.blue, pop_data.green, pop_data.red};
            packed_px.out_bytes = BYTES_THREE;
         end
         DST_RGBA: begin
            packed_px.out_pixel = {pop_data.alpha, pop_data.blue, pop_data.green,
                                   pop_data.red};
         end
         DST_ARGB: begin
            packed_px.out_pixel = {pop_data.blue, pop_data.green, pop_data.red,
                                   pop_data.alpha};
         end
         DST_BGR: begin
            packed_px.out_pixel = {NO_COLOUR, pop_data.red, pop_data.green, pop_data.blue};
            packed_px.out_bytes = BYTES_THREE;
         end
         DST_BGRA: begin
            packed_px.out_pixel = {pop_data.alpha, pop_data.red, pop_data.green,
                                   pop_data.blue};
         end
         DST_ABGR: begin
            packed_px.out_pixel = {pop_data.red, pop_data.green, pop_data.blue,
                                   pop_data.alpha};
         end
         default: begin
            packed_px.out_pixel = {24'd0, pop_data.alpha};
            packed_px.out_bytes = BYTES_ONE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= packed_px;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hdl/pfc_checker.sv
// pfc_checker: port-level checks on the pixel format converter responses
// depends on pfc_pkg; bound to pixel_format_converter_unit

module pfc_checker
   import pfc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // no response straight out of reset
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // byte count is one of the legal sizes
   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.out_bytes == BYTES_ONE ||
                     rsp_payload.out_bytes == BYTES_THREE ||
                     rsp_payload.out_bytes == BYTES_FOUR))
      else $error("illegal byte count");

   // bytes past the count are zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.out_bytes != BYTES_ONE ||
                      rsp_payload.out_pixel[31:8] == 24'd0) &&
                     (rsp_payload.out_bytes != BYTES_THREE ||
                      rsp_payload.out_pixel[31:24] == 8'd0)))
      else $error("unused response bytes not zero");

endmodule

bind pixel_format_converter_unit pfc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
